@@ sv/iee_pkg.sv @@
`default_nettype none
package iee_pkg;

	localparam int OSD = 16;
	localparam int VSD = 16;
	localparam int FRAC = 16;
	localparam int OIW = $clog2(OSD);
	localparam int ODW = $clog2(OSD + 1);
	localparam int VIW = $clog2(VSD);
	localparam int VDW = $clog2(VSD + 1);
	localparam int DW = 48 + FRAC;
	localparam int CNTW = $clog2(DW + 1);

	typedef enum logic [2:0] {
		OP_NUM   = 3'd0,
		OP_PLUS  = 3'd1,
		OP_MINUS = 3'd2,
		OP_TIMES = 3'd3,
		OP_DIV   = 3'd4,
		OP_OPEN  = 3'd5,
		OP_CLOSE = 3'd6,
		OP_BAD   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_OVF = 2'd2,
		ST_BAD = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [47:0] number_value;
		logic               end_of_expression;
	} token_t;

	typedef struct packed {
		logic signed [47:0] result_value;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic               start;
		op_t                op;
		logic signed [47:0] a;
		logic signed [47:0] b;
	} alu_req_t;

	typedef struct packed {
		logic               done;
		logic signed [47:0] res;
		logic               dz;
	} alu_rsp_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_DONE
	} alu_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TOKEN,
		S_FETCH,
		S_OPLOOP,
		S_CLOSE,
		S_DRAIN,
		S_APPLY,
		S_WAITA,
		S_POPA,
		S_EXEC,
		S_FINAL
	} state_t;

	localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] NEG_MIN = 48'sh8000_0000_0000;

	function automatic logic [1:0] prio(input logic [2:0] op);
		logic [1:0] p;
		p = 2'd0;
		if (op == OP_PLUS || op == OP_MINUS) p = 2'd1;
		if (op == OP_TIMES || op == OP_DIV) p = 2'd2;
		return p;
	endfunction

	// overflow and malformed statuses stick, divide by zero only over ok
	function automatic status_t raise(input status_t cur, input status_t s);
		status_t r;
		r = cur;
		if (s == ST_OVF || s == ST_BAD) begin
			if (cur == ST_OK || cur == ST_DZ) r = s;
		end else if (cur == ST_OK) begin
			r = s;
		end
		return r;
	endfunction

	function automatic logic [47:0] mag(input logic signed [47:0] v);
		return v[47] ? 48'(-v) : v;
	endfunction

	function automatic logic signed [47:0] from_mag(input logic neg, input logic ovf,
			input logic [47:0] m);
		logic signed [47:0] r;
		if (neg) r = ovf ? NEG_MIN : 48'(-m);
		else r = ovf ? POS_MAX : m;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/iee_alu.sv @@
`default_nettype none
module iee_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  iee_pkg::alu_req_t req,
	output iee_pkg::alu_rsp_t rsp
);
	import iee_pkg::*;

	alu_state_t         ast_q, ast_d;
	logic [CNTW-1:0]    cnt_q;
	logic               neg_q;
	logic [47:0]        x_q, y_q, r_q;
	logic [95:0]        acc_q;
	logic [DW-1:0]      rq_q;
	logic signed [47:0] res_q;
	logic               dz_q;

	logic [49:0]        add_a, add_b, sum;
	logic               add_sub;
	logic [95:0]        prod_sh;
	logic               qbit;

	// single shared adder for add, subtract, multiply and divide steps
	always_comb begin
		unique case (ast_q)
			A_MUL: begin
				add_a = {2'b0, acc_q[95:48]};
				add_b = acc_q[0] ? {2'b0, x_q} : '0;
				add_sub = 1'b0;
			end
			A_DIV: begin
				add_a = {1'b0, r_q, rq_q[DW-1]};
				add_b = {2'b0, y_q};
				add_sub = 1'b1;
			end
			default: begin
				add_a = {{2{req.a[47]}}, req.a};
				add_b = {{2{req.b[47]}}, req.b};
				add_sub = (req.op == OP_MINUS);
			end
		endcase
		sum = add_a + (add_sub ? ~add_b : add_b) + {49'b0, add_sub};
		qbit = ~sum[49];
		prod_sh = acc_q >> FRAC;
		ast_d = ast_q;
		unique case (ast_q)
			A_IDLE: if (req.start) begin
				priority if (req.op == OP_PLUS || req.op == OP_MINUS) ast_d = A_DONE;
				else if (req.op == OP_TIMES) ast_d = A_MUL;
				else if (req.b == '0) ast_d = A_DONE;
				else ast_d = A_DIV;
			end
			A_MUL: if (cnt_q == '0) ast_d = A_DONE;
			A_DIV: if (cnt_q == '0) ast_d = A_DONE;
			A_DONE: ast_d = A_IDLE;
			default: ast_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ast_q <= A_IDLE;
		end else begin
			ast_q <= ast_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ast_q)
			A_IDLE: if (req.start) begin
				neg_q <= req.a[47] ^ req.b[47];
				x_q <= mag(req.a);
				y_q <= mag(req.b);
				acc_q <= {48'b0, mag(req.b)};
				rq_q <= DW'(mag(req.a)) << FRAC;
				r_q <= '0;
				dz_q <= 1'b0;
				if (req.op == OP_TIMES) cnt_q <= CNTW'(48);
				else cnt_q <= CNTW'(DW);
				if (req.op == OP_PLUS || req.op == OP_MINUS) begin
					if (sum[49:47] != {3{sum[49]}}) res_q <= sum[49] ? NEG_MIN : POS_MAX;
					else res_q <= sum[47:0];
				end else if (req.op == OP_DIV && req.b == '0) begin
					res_q <= '0;
					dz_q <= 1'b1;
				end
			end
			A_MUL: begin
				if (cnt_q != '0) begin
					acc_q <= {sum[48:0], acc_q[47:1]};
					cnt_q <= cnt_q - 1'b1;
				end else begin
					res_q <= from_mag(neg_q, |prod_sh[95:47], prod_sh[47:0]);
				end
			end
			A_DIV: begin
				if (cnt_q != '0) begin
					r_q <= qbit ? sum[47:0] : {r_q[46:0], rq_q[DW-1]};
					rq_q <= {rq_q[DW-2:0], qbit};
					cnt_q <= cnt_q - 1'b1;
				end else begin
					res_q <= from_mag(neg_q, |rq_q[DW-1:47], rq_q[47:0]);
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = (ast_q == A_DONE);
	assign rsp.res = res_q;
	assign rsp.dz = dz_q;

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("alu done held");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ast_q == A_MUL) |-> cnt_q <= CNTW'(48)) else $error("mul count range");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.done && rsp.dz) |-> rsp.res == '0) else $error("divide by zero value");

endmodule
`default_nettype wire

@@ sv/infix_expression_evaluator.sv @@
`default_nettype none
// Infix expression evaluator. Tokens arrive one word at a time; the block holds
// token_stall high while it works on a word. A number or open parenthesis is
// pushed onto its stack; an operator or close parenthesis pops and applies operators,
// a multiply by shift and add and a divide by restoring division of 48 + 16
// fraction bits, both in the shared unit.
// The word marked end drains the operator stack the same way and then presents
// one result word with the value and a status (0 ok, 1 divide by zero, 2 stack
// overflow, 3 malformed). The result sits in an output register, so the next
// token is taken while it waits.
module infix_expression_evaluator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             token_valid,
	output logic             token_stall,
	input  iee_pkg::token_t  token,
	output logic             result_valid,
	input  logic             result_stall,
	output iee_pkg::result_t result
);
	import iee_pkg::*;

	state_t             state_q, state_d, ret_q, ret_d;
	logic [ODW-1:0]     od_q, od_d;
	logic [VDW-1:0]     vd_q, vd_d;
	status_t            sticky_q, sticky_d;
	logic [2:0]         tok_op_q;
	logic signed [47:0] tok_num_q;
	logic               tok_eoe_q;
	logic [2:0]         apply_op_q;
	logic signed [47:0] b_q;

	logic [2:0]         ostk [OSD];
	logic signed [47:0] vstk [VSD];
	logic [2:0]         otop_q;
	logic signed [47:0] vtop_q;

	logic               o_we, v_we;
	logic [2:0]         o_wdata;
	logic signed [47:0] v_wdata;
	logic               take, load_out, latch_b, alu_start;
	logic               res_valid_q;
	result_t            res_q;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic               live;

	assign live = (sticky_q == ST_OK || sticky_q == ST_DZ);
	assign take = token_valid && !token_stall;
	assign token_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		od_d = od_q;
		vd_d = vd_q;
		sticky_d = sticky_q;
		o_we = 1'b0;
		v_we = 1'b0;
		o_wdata = tok_op_q;
		v_wdata = tok_num_q;
		load_out = 1'b0;
		latch_b = 1'b0;
		alu_start = 1'b0;
		unique case (state_q)
			S_IDLE: if (take) state_d = S_TOKEN;
			S_TOKEN: begin
				state_d = tok_eoe_q ? S_FETCH : S_IDLE;
				ret_d = S_DRAIN;
				if (live) begin
					priority if (tok_op_q == OP_NUM) begin
						if (vd_q >= VDW'(VSD)) sticky_d = raise(sticky_q, ST_OVF);
						else begin
							v_we = 1'b1;
							vd_d = vd_q + 1'b1;
						end
					end else if (tok_op_q == OP_OPEN) begin
						if (od_q >= ODW'(OSD)) sticky_d = raise(sticky_q, ST_OVF);
						else begin
							o_we = 1'b1;
							od_d = od_q + 1'b1;
						end
					end else if (tok_op_q == OP_CLOSE) begin
						state_d = S_FETCH;
						ret_d = S_CLOSE;
					end else if (tok_op_q == OP_BAD) begin
						sticky_d = raise(sticky_q, ST_BAD);
					end else begin
						state_d = S_FETCH;
						ret_d = S_OPLOOP;
					end
				end
			end
			S_FETCH: state_d = ret_q;
			S_OPLOOP: begin
				if (live && od_q != '0 && prio(otop_q) >= prio(tok_op_q)) begin
					state_d = S_APPLY;
				end else begin
					if (live) begin
						if (od_q >= ODW'(OSD)) sticky_d = raise(sticky_q, ST_OVF);
						else begin
							o_we = 1'b1;
							od_d = od_q + 1'b1;
						end
					end
					state_d = tok_eoe_q ? S_FETCH : S_IDLE;
					ret_d = S_DRAIN;
				end
			end
			S_CLOSE: begin
				if (live && od_q != '0 && otop_q != OP_OPEN) begin
					state_d = S_APPLY;
				end else begin
					if (live) begin
						if (od_q == '0) sticky_d = raise(sticky_q, ST_BAD);
						else od_d = od_q - 1'b1;
					end
					state_d = tok_eoe_q ? S_FETCH : S_IDLE;
					ret_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (live && od_q != '0) begin
					if (otop_q == OP_OPEN) begin
						sticky_d = raise(sticky_q, ST_BAD);
						state_d = S_FINAL;
					end else begin
						state_d = S_APPLY;
					end
				end else begin
					if (live && vd_q != VDW'(1)) sticky_d = raise(sticky_q, ST_BAD);
					state_d = S_FINAL;
				end
			end
			S_APPLY: begin
				od_d = od_q - 1'b1;
				if (vd_q < VDW'(2)) begin
					sticky_d = raise(sticky_q, ST_BAD);
					state_d = S_FETCH;
				end else begin
					latch_b = 1'b1;
					vd_d = vd_q - 1'b1;
					state_d = S_WAITA;
				end
			end
			S_WAITA: state_d = S_POPA;
			S_POPA: begin
				alu_start = 1'b1;
				vd_d = vd_q - 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: if (alu_rsp.done) begin
				v_we = 1'b1;
				v_wdata = alu_rsp.res;
				vd_d = vd_q + 1'b1;
				if (alu_rsp.dz) sticky_d = raise(sticky_q, ST_DZ);
				state_d = S_FETCH;
			end
			S_FINAL: if (!res_valid_q || !result_stall) begin
				load_out = 1'b1;
				od_d = '0;
				vd_d = '0;
				sticky_d = ST_OK;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_DRAIN;
			od_q <= '0;
			vd_q <= '0;
			sticky_q <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			od_q <= od_d;
			vd_q <= vd_d;
			sticky_q <= sticky_d;
			if (load_out) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_op_q <= token.operation;
			tok_num_q <= token.number_value;
			tok_eoe_q <= token.end_of_expression;
		end
		if (state_q == S_APPLY) apply_op_q <= otop_q;
		if (latch_b) b_q <= vtop_q;
		if (load_out) begin
			res_q.status <= sticky_q;
			res_q.result_value <= live ? vtop_q : '0;
		end
	end

	// stacks: one write and one registered read at top of stack per cycle
	always_ff @(posedge clk) begin
		if (o_we) ostk[od_q[OIW-1:0]] <= o_wdata;
		otop_q <= ostk[OIW'(od_q - 1'b1)];
	end

	always_ff @(posedge clk) begin
		if (v_we) vstk[vd_q[VIW-1:0]] <= v_wdata;
		vtop_q <= vstk[VIW'(vd_q - 1'b1)];
	end

	assign alu_req.start = alu_start;
	assign alu_req.op = op_t'(apply_op_q);
	assign alu_req.a = vtop_q;
	assign alu_req.b = b_q;

	iee_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	assign result_valid = res_valid_q;
	assign result = res_q;

	a_od_range: assert property (@(posedge clk) disable iff (!arst_n)
		od_q <= ODW'(OSD)) else $error("operator depth out of range");
	a_vd_range: assert property (@(posedge clk) disable iff (!arst_n)
		vd_q <= VDW'(VSD)) else $error("value depth out of range");
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (od_q == '0 && vd_q == '0 && sticky_q == ST_OK))
		else $error("state not cleared after result");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == ST_OVF || result.status == ST_BAD))
		|-> result.result_value == '0) else $error("value on failed expression");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
import iee_pkg::*;

class expr_checker;
	logic signed [47:0] vals[VSD];
	logic [2:0]         ops[OSD];
	int                 op_cnt;
	int                 val_cnt;
	status_t            flag;
	result_t            pending_results[$];
	int                 errors;

	function new();
		op_cnt = 0;
		val_cnt = 0;
		flag = ST_OK;
		errors = 0;
	endfunction

	function void raise_flag(status_t s);
		if (s == ST_OVF || s == ST_BAD) begin
			if (flag == ST_OK || flag == ST_DZ) flag = s;
		end else if (flag == ST_OK) begin
			flag = s;
		end
	endfunction

	function bit severe();
		return flag == ST_OVF || flag == ST_BAD;
	endfunction

	function int rank(logic [2:0] op);
		if (op == OP_PLUS || op == OP_MINUS) return 1;
		if (op == OP_TIMES || op == OP_DIV) return 2;
		return 0;
	endfunction

	function logic [47:0] abs48(logic signed [47:0] v);
		return v[47] ? 48'(-v) : v;
	endfunction

	// signed value from a sign and a wide magnitude, saturating
	function logic signed [47:0] clamp_mag(bit neg, logic [95:0] m);
		if (neg) begin
			if (m >= 96'h8000_0000_0000) return POS_MAX + 48'sd1;
			return 48'(-m[47:0]);
		end
		if (m > 96'h7FFF_FFFF_FFFF) return POS_MAX;
		return m[47:0];
	endfunction

	function logic signed [47:0] clamp_sum(logic signed [48:0] s);
		if (s > 49'sh0_7FFF_FFFF_FFFF) return POS_MAX;
		if (s < -49'sh0_8000_0000_0000) return POS_MAX + 48'sd1;
		return s[47:0];
	endfunction

	function logic signed [47:0] arith(logic [2:0] op, logic signed [47:0] a,
			logic signed [47:0] b);
		logic [95:0] p;
		bit          neg;
		neg = a[47] ^ b[47];
		case (op)
			OP_PLUS:  return clamp_sum($signed({a[47], a}) + $signed({b[47], b}));
			OP_MINUS: return clamp_sum($signed({a[47], a}) - $signed({b[47], b}));
			OP_TIMES: begin
				p = {48'b0, abs48(a)} * {48'b0, abs48(b)};
				return clamp_mag(neg, p >> FRAC);
			end
			default: begin
				if (abs48(b) == 0) begin
					raise_flag(ST_DZ);
					return 0;
				end
				p = ({48'b0, abs48(a)} << FRAC) / {48'b0, abs48(b)};
				return clamp_mag(neg, p);
			end
		endcase
	endfunction

	function void push_val(logic signed [47:0] v);
		if (val_cnt >= VSD) raise_flag(ST_OVF);
		else vals[val_cnt++] = v;
	endfunction

	function void push_op(logic [2:0] op);
		if (op_cnt >= OSD) raise_flag(ST_OVF);
		else ops[op_cnt++] = op;
	endfunction

	function void reduce_top();
		logic [2:0]         op;
		logic signed [47:0] a, b, r;
		op = ops[--op_cnt];
		if (val_cnt < 2) begin
			raise_flag(ST_BAD);
			return;
		end
		b = vals[--val_cnt];
		a = vals[--val_cnt];
		r = arith(op, a, b);
		push_val(r);
	endfunction

	function void note_token(token_t t);
		result_t r;
		if (!severe()) begin
			case (t.operation)
				OP_NUM: push_val(t.number_value);
				OP_PLUS, OP_MINUS, OP_TIMES, OP_DIV: begin
					while (!severe() && op_cnt > 0 && rank(ops[op_cnt-1]) >= rank(t.operation))
						reduce_top();
					if (!severe()) push_op(t.operation);
				end
				OP_OPEN: push_op(OP_OPEN);
				OP_CLOSE: begin
					while (!severe() && op_cnt > 0 && ops[op_cnt-1] != OP_OPEN)
						reduce_top();
					if (!severe()) begin
						if (op_cnt == 0) raise_flag(ST_BAD);
						else op_cnt--;
					end
				end
				default: raise_flag(ST_BAD);
			endcase
		end
		if (!t.end_of_expression) return;
		while (!severe() && op_cnt > 0) begin
			if (ops[op_cnt-1] == OP_OPEN) raise_flag(ST_BAD);
			else reduce_top();
		end
		if (!severe() && val_cnt != 1) raise_flag(ST_BAD);
		r.result_value = severe() ? '0 : vals[0];
		r.status = flag;
		pending_results = {pending_results, r};
		op_cnt = 0;
		val_cnt = 0;
		flag = ST_OK;
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result value %h status %0d", $time,
				got.result_value, got.status);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (got.result_value !== want.result_value) begin
			$display("%0t: result_value expected %h actual %h", $time,
				want.result_value, got.result_value);
			errors++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			errors++;
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic    clk = 0;
	logic    arst_n = 0;
	logic    token_valid = 0;
	logic    token_stall;
	token_t  token = '0;
	logic    result_valid;
	logic    result_stall = 0;
	result_t result;

	expr_checker sb = new();
	token_t      tok_q[$];
	int          sent = 0;
	int          tx_pct = 0;
	int          rx_pct = 0;
	bit          hold_req = 0;

	infix_expression_evaluator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token(token),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (result_valid && !result_stall) sb.check_result(result);
		if (token_valid && !token_stall) sb.note_token(token);
	end

	// receiver, with one long hold-off so the block backs up
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				hold_left = 600;
				held = 1;
			end
			if (hold_left > 0) begin
				result_stall <= 1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < rx_pct);
			end
		end
	end

	function automatic logic signed [47:0] pick_number();
		case ($urandom_range(9))
			0: return POS_MAX;
			1: return POS_MAX + 48'sd1;
			2: return 0;
			3, 4: return 48'({$urandom, $urandom});
			default: return $signed(48'($signed($urandom_range(40)) - 20)) <<< FRAC;
		endcase
	endfunction

	function automatic token_t mk(logic [2:0] op, logic signed [47:0] v, bit last);
		token_t t;
		t.operation = op;
		t.number_value = v;
		t.end_of_expression = last;
		return t;
	endfunction

	task automatic send_queue();
		token_t t;
		while (tok_q.size() > 0) begin
			t = tok_q.pop_front();
			if ($urandom_range(99) < tx_pct) begin
				token_valid <= 0;
				repeat ($urandom_range(4, 1)) @(posedge clk);
			end
			token_valid <= 1;
			token <= t;
			@(posedge clk);
			while (token_stall) @(posedge clk);
			sent++;
		end
		token_valid <= 0;
	endtask

	// well-formed expression with random content, sometimes broken
	task automatic build_expression();
		int  n, opens, k;
		bit  need_operand;
		n = $urandom_range(12, 1);
		opens = 0;
		need_operand = 1;
		for (int i = 0; i < n; i++) begin
			if (need_operand) begin
				if (opens < 4 && $urandom_range(3) == 0) begin
					tok_q = {tok_q, mk(OP_OPEN, pick_number(), 0)};
					opens++;
				end else begin
					tok_q = {tok_q, mk(OP_NUM, pick_number(), 0)};
					need_operand = 0;
				end
			end else if (opens > 0 && $urandom_range(2) == 0) begin
				tok_q = {tok_q, mk(OP_CLOSE, pick_number(), 0)};
				opens--;
			end else begin
				tok_q = {tok_q, mk(3'($urandom_range(4, 1)), pick_number(), 0)};
				need_operand = 1;
			end
		end
		if (need_operand) tok_q = {tok_q, mk(OP_NUM, pick_number(), 0)};
		repeat (opens) tok_q = {tok_q, mk(OP_CLOSE, pick_number(), 0)};
		if ($urandom_range(99) < 15) begin
			k = $urandom_range(tok_q.size() - 1);
			if ($urandom_range(1)) tok_q.delete(k);
			else tok_q[k].operation = 3'($urandom_range(7));
		end
		if (tok_q.size() == 0) tok_q = {tok_q, mk(OP_NUM, pick_number(), 0)};
		tok_q[tok_q.size()-1].end_of_expression = 1;
	endtask

	initial begin
		logic signed [47:0] one;
		one = 48'sd1 <<< FRAC;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes and saturation
		tok_q = '{mk(OP_NUM, POS_MAX, 0), mk(OP_PLUS, 0, 0), mk(OP_NUM, one, 1)};
		send_queue();
		tok_q = '{mk(OP_NUM, POS_MAX + 48'sd1, 0), mk(OP_MINUS, 0, 0), mk(OP_NUM, one, 1)};
		send_queue();
		tok_q = '{mk(OP_NUM, POS_MAX + 48'sd1, 0), mk(OP_TIMES, 0, 0),
			mk(OP_NUM, POS_MAX + 48'sd1, 1)};
		send_queue();
		// precedence and parentheses, negative divide
		tok_q = '{mk(OP_OPEN, 0, 0), mk(OP_NUM, 7 * one, 0), mk(OP_MINUS, 0, 0),
			mk(OP_NUM, 2 * one, 0), mk(OP_CLOSE, 0, 0), mk(OP_DIV, 0, 0),
			mk(OP_NUM, -3 * one, 0), mk(OP_TIMES, 0, 0), mk(OP_NUM, 5, 1)};
		send_queue();
		// divide by zero, then a malformed expression with an extra operand
		tok_q = '{mk(OP_NUM, one, 0), mk(OP_DIV, 0, 0), mk(OP_NUM, 0, 1)};
		send_queue();
		tok_q = '{mk(OP_NUM, one, 0), mk(OP_DIV, 0, 0), mk(OP_NUM, 0, 0), mk(OP_NUM, one, 1)};
		send_queue();
		// unmatched close, unmatched open, unknown token, too few operands
		tok_q = '{mk(OP_NUM, one, 0), mk(OP_CLOSE, 0, 1)};
		send_queue();
		tok_q = '{mk(OP_OPEN, 0, 0), mk(OP_NUM, one, 1)};
		send_queue();
		tok_q = '{mk(OP_BAD, 0, 0), mk(OP_NUM, one, 1)};
		send_queue();
		tok_q = '{mk(OP_NUM, one, 0), mk(OP_PLUS, 0, 1)};
		send_queue();
		// operator stack overflow
		repeat (OSD + 1) tok_q = {tok_q, mk(OP_OPEN, 0, 0)};
		tok_q = {tok_q, mk(OP_NUM, one, 1)};
		send_queue();
		// value stack overflow
		repeat (VSD + 1) tok_q = {tok_q, mk(OP_NUM, one, 0)};
		tok_q = {tok_q, mk(OP_NUM, one, 1)};
		send_queue();

		while (sent < 450) begin
			if (sent < 170) begin
				tx_pct = 26;
				rx_pct = 79;
			end else if (sent < 330) begin
				tx_pct = 79;
				rx_pct = 26;
				hold_req = 1;
			end else begin
				tx_pct = 0;
				rx_pct = 0;
			end
			build_expression();
			send_queue();
		end
		rx_pct = 0;

		while (sb.pending_results.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end

	initial begin
		#30ms;
		$display("testbench: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
